// ----- src/trie_pkg.sv -----
// Shared types and constants for the three-register instruction executor.
`timescale 1ns / 1ps

package trie_pkg;

  // Data path and iteration sizes
  localparam int DATA_W   = 32;
  localparam int PC_OUT_W = 16;
  localparam int STEP_W   = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  localparam logic [DATA_W-1:0] INT_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] MINUS_ONE = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] ONE       = DATA_W'(1);

  // Operation codes
  localparam logic [3:0] ACT_ADD  = 4'd0;
  localparam logic [3:0] ACT_SUB  = 4'd1;
  localparam logic [3:0] ACT_MUL  = 4'd2;
  localparam logic [3:0] ACT_DIV  = 4'd3;
  localparam logic [3:0] ACT_MOVE = 4'd4;
  localparam logic [3:0] ACT_INC  = 4'd5;
  localparam logic [3:0] ACT_DEC  = 4'd6;
  localparam logic [3:0] ACT_LOAD = 4'd7;
  localparam logic [3:0] ACT_JUMP = 4'd8;
  localparam logic [3:0] ACT_CJMP = 4'd9;

  // Register select codes; the last one names no register
  localparam logic [1:0] REG_A    = 2'd0;
  localparam logic [1:0] REG_B    = 2'd1;
  localparam logic [1:0] REG_C    = 2'd2;
  localparam logic [1:0] REG_NONE = 2'd3;

  localparam int IN_W  = 104;
  localparam int OUT_W = 152;

  // Input item as packed on in_tdata, last field in the lowest bits
  typedef struct packed {
    logic [6:0]        pad;
    logic [7:0]        instr_length;
    logic [15:0]       jump_target;
    logic [DATA_W-1:0] mem_value;
    logic [DATA_W-1:0] immediate;
    logic [1:0]        src_reg;
    logic              src_is_reg;
    logic [1:0]        dest_reg;
    logic [3:0]        action;
  } in_item_t;

  // Result item as packed on out_tdata, last field in the lowest bits
  typedef struct packed {
    logic [6:0]          pad;
    logic                fault;
    logic [PC_OUT_W-1:0] next_pc;
    logic [DATA_W-1:0]   out_loop;
    logic [DATA_W-1:0]   out_c;
    logic [DATA_W-1:0]   out_b;
    logic [DATA_W-1:0]   out_a;
  } out_item_t;

endpackage

// ----- src/three_register_instruction_executor.sv -----
// Top level of the three-register instruction executor.
`timescale 1ns / 1ps

// Executes one decoded instruction per input transfer against registers A, B, C,
// the loop register and the program counter, and returns one result transfer with
// the machine state after it. All data arithmetic runs through a single 33-bit
// adder/subtractor under a small sequencer. Add, subtract, increment, decrement,
// move, load, jump and counted jump pass through one execute state before commit;
// multiply runs 32 shift-add steps and divide runs operand sign fixes plus 32
// restoring steps, both at one bit per cycle around the shared adder. A multiply
// or divide that writes no register, or a divide that raises a fault, skips
// the step loop. The input is not ready while an instruction is at work; it is
// ready again while a finished result still waits on the output. A configuration
// write copies its value into the loop register.
module three_register_instruction_executor #(
  parameter int ADDR_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Instruction input
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // action[3:0], dest_reg[5:4], src_is_reg[6], src_reg[8:7], immediate[40:9],
  // mem_value[72:41], jump_target[88:73], instr_length[96:89], zero pad
  input  logic [trie_pkg::IN_W-1:0]   in_tdata,
  // Result output
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_a[31:0], out_b[63:32], out_c[95:64], out_loop[127:96],
  // next_pc[143:128], fault[144], zero pad
  output logic [trie_pkg::OUT_W-1:0]  out_tdata,
  // Loop register start value
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [trie_pkg::DATA_W-1:0] cfg_data
);

  localparam int DW = trie_pkg::DATA_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DABS = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIX  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  trie_pkg::in_item_t  in_item;
  trie_pkg::out_item_t out_item;

  // Architectural state
  logic [DW-1:0]         reg_a_r, reg_a_nxt;
  logic [DW-1:0]         reg_b_r, reg_b_nxt;
  logic [DW-1:0]         reg_c_r, reg_c_nxt;
  logic [DW-1:0]         loop_r, loop_nxt;
  logic [ADDR_WIDTH-1:0] pc_r, pc_nxt;

  // Sequencer and working registers
  logic [2:0]                  state_r, state_nxt;
  logic [3:0]                  act_r, act_nxt;
  logic [1:0]                  dst_r, dst_nxt;
  logic                        wen_r, wen_nxt;
  logic                        fault_r, fault_nxt;
  logic                        neg_r, neg_nxt;
  logic [DW-1:0]               opa_r, opa_nxt;
  logic [DW-1:0]               opb_r, opb_nxt;
  logic [DW-1:0]               res_r, res_nxt;
  logic [trie_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_WIDTH-1:0]       npc_r, npc_nxt;

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  logic [trie_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  // Shared adder/subtractor
  logic [DW-1:0] add_a, add_b;
  logic          add_sub;
  logic [DW:0]   add_y;

  // Decode helpers at accept time
  logic                  in_fire;
  logic                  done_go;
  logic [DW-1:0]         dst_val, src_val, src_opnd;
  logic                  dst_ok, src_ok, is_alu;
  logic                  in_wen;
  logic [ADDR_WIDTH-1:0] pc_seq, pc_tgt;

  assign in_item   = trie_pkg::in_item_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign done_go   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Register file reads for destination and source
  always_comb begin
    unique case (in_item.dest_reg)
      trie_pkg::REG_A: dst_val = reg_a_r;
      trie_pkg::REG_B: dst_val = reg_b_r;
      trie_pkg::REG_C: dst_val = reg_c_r;
      default:         dst_val = '0;
    endcase
    unique case (in_item.src_reg)
      trie_pkg::REG_A: src_val = reg_a_r;
      trie_pkg::REG_B: src_val = reg_b_r;
      trie_pkg::REG_C: src_val = reg_c_r;
      default:         src_val = '0;
    endcase
  end

  // Operand validity and write enable of the decoded instruction
  always_comb begin
    dst_ok   = (in_item.dest_reg != trie_pkg::REG_NONE);
    src_ok   = in_item.src_is_reg ? (in_item.src_reg != trie_pkg::REG_NONE) :
                                    (in_item.immediate != '0);
    src_opnd = in_item.src_is_reg ? src_val : in_item.immediate;
    is_alu   = (in_item.action <= trie_pkg::ACT_MOVE);
    if (is_alu) begin
      in_wen = dst_ok && src_ok &&
               !((in_item.action == trie_pkg::ACT_MOVE) && in_item.src_is_reg &&
                 (in_item.src_reg == in_item.dest_reg));
    end else begin
      in_wen = dst_ok && ((in_item.action == trie_pkg::ACT_INC) ||
                          (in_item.action == trie_pkg::ACT_DEC) ||
                          (in_item.action == trie_pkg::ACT_LOAD));
    end
  end

  // Sequential and jump addresses
  assign pc_seq = pc_r + ADDR_WIDTH'(in_item.instr_length);
  assign pc_tgt = ADDR_WIDTH'(in_item.jump_target);

  // Operand selection of the shared adder
  always_comb begin
    add_a   = opa_r;
    add_b   = opb_r;
    add_sub = 1'b0;
    unique case (state_r)
      S_EXEC: begin
        if (act_r == trie_pkg::ACT_CJMP) begin
          add_a   = loop_r;
          add_b   = trie_pkg::ONE;
          add_sub = 1'b1;
        end else if (act_r == trie_pkg::ACT_DIV) begin
          add_a   = '0;
          add_b   = opa_r;
          add_sub = 1'b1;
        end else begin
          add_sub = (act_r == trie_pkg::ACT_SUB) || (act_r == trie_pkg::ACT_DEC);
        end
      end
      S_MUL: begin
        add_a = res_r;
        add_b = opa_r;
      end
      S_DABS: begin
        add_a   = '0;
        add_b   = opb_r;
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_a   = {res_r[DW-2:0], opa_r[DW-1]};
        add_b   = opb_r;
        add_sub = 1'b1;
      end
      S_FIX: begin
        add_a   = '0;
        add_b   = opa_r;
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_y = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (DW + 1)'(add_sub);

  // Sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    dst_nxt       = dst_r;
    wen_nxt       = wen_r;
    fault_nxt     = fault_r;
    neg_nxt       = neg_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    npc_nxt       = npc_r;
    reg_a_nxt     = reg_a_r;
    reg_b_nxt     = reg_b_r;
    reg_c_nxt     = reg_c_r;
    loop_nxt      = loop_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_item      = '0;

    unique case (state_r)
      // Take a configuration write or latch a new instruction
      S_IDLE: begin
        if (cfg_valid) begin
          loop_nxt = cfg_data;
        end else if (in_fire) begin
          act_nxt   = in_item.action;
          dst_nxt   = in_item.dest_reg;
          wen_nxt   = in_wen;
          fault_nxt = 1'b0;
          opa_nxt   = dst_val;
          priority if ((in_item.action == trie_pkg::ACT_INC) ||
                       (in_item.action == trie_pkg::ACT_DEC)) begin
            opb_nxt = trie_pkg::ONE;
          end else if (in_item.action == trie_pkg::ACT_LOAD) begin
            opb_nxt = in_item.mem_value;
          end else begin
            opb_nxt = src_opnd;
          end
          priority if (in_item.action == trie_pkg::ACT_JUMP) begin
            npc_nxt = pc_tgt;
          end else if ((in_item.action == trie_pkg::ACT_CJMP) &&
                       !loop_r[DW-1] && (loop_r != '0)) begin
            npc_nxt = pc_tgt;
          end else begin
            npc_nxt = pc_seq;
          end
          state_nxt = S_EXEC;
        end
      end

      // Single-step operations, or setup of the multi-step ones
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (act_r)
          trie_pkg::ACT_ADD, trie_pkg::ACT_SUB,
          trie_pkg::ACT_INC, trie_pkg::ACT_DEC: begin
            res_nxt = add_y[DW-1:0];
          end
          trie_pkg::ACT_MOVE, trie_pkg::ACT_LOAD: begin
            res_nxt = opb_r;
          end
          trie_pkg::ACT_MUL: begin
            res_nxt = '0;
            cnt_nxt = '0;
            if (wen_r) begin
              state_nxt = S_MUL;
            end
          end
          trie_pkg::ACT_DIV: begin
            if (!wen_r) begin
              fault_nxt = 1'b0;
            end else if ((opb_r == '0) ||
                         ((opa_r == trie_pkg::INT_MIN) && (opb_r == trie_pkg::MINUS_ONE))) begin
              // Undefined quotient: keep the destination and flag it
              fault_nxt = 1'b1;
              wen_nxt   = 1'b0;
            end else begin
              neg_nxt   = opa_r[DW-1] ^ opb_r[DW-1];
              if (opa_r[DW-1]) begin
                opa_nxt = add_y[DW-1:0];
              end
              state_nxt = S_DABS;
            end
          end
          trie_pkg::ACT_CJMP: begin
            loop_nxt = add_y[DW-1:0];
          end
          default: begin
            res_nxt = res_r;
          end
        endcase
      end

      // Shift-add multiply, one multiplier bit per cycle
      S_MUL: begin
        if (opb_r[0]) begin
          res_nxt = add_y[DW-1:0];
        end
        opa_nxt = {opa_r[DW-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[DW-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == trie_pkg::LAST_STEP) begin
          state_nxt = S_DONE;
        end
      end

      // Divisor magnitude, then clear the partial remainder
      S_DABS: begin
        if (opb_r[DW-1]) begin
          opb_nxt = add_y[DW-1:0];
        end
        res_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end

      // Restoring divide, one quotient bit per cycle
      S_DIV: begin
        if (add_y[DW]) begin
          res_nxt = add_y[DW-1:0];
        end else begin
          res_nxt = add_a;
        end
        opa_nxt = {opa_r[DW-2:0], add_y[DW]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == trie_pkg::LAST_STEP) begin
          state_nxt = S_FIX;
        end
      end

      // Quotient sign
      S_FIX: begin
        res_nxt   = neg_r ? add_y[DW-1:0] : opa_r;
        state_nxt = S_DONE;
      end

      // Commit the instruction and load the output register
      S_DONE: begin
        if (done_go) begin
          if (wen_r && (dst_r == trie_pkg::REG_A)) reg_a_nxt = res_r;
          if (wen_r && (dst_r == trie_pkg::REG_B)) reg_b_nxt = res_r;
          if (wen_r && (dst_r == trie_pkg::REG_C)) reg_c_nxt = res_r;
          pc_nxt            = npc_r;
          out_item.out_a    = reg_a_nxt;
          out_item.out_b    = reg_b_nxt;
          out_item.out_c    = reg_c_nxt;
          out_item.out_loop = loop_r;
          out_item.next_pc  = trie_pkg::PC_OUT_W'(npc_r);
          out_item.fault    = fault_r;
          out_data_nxt      = out_item;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      reg_a_r     <= '0;
      reg_b_r     <= '0;
      reg_c_r     <= '0;
      loop_r      <= '0;
      pc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      reg_a_r     <= reg_a_nxt;
      reg_b_r     <= reg_b_nxt;
      reg_c_r     <= reg_c_nxt;
      loop_r      <= loop_nxt;
      pc_r        <= pc_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    dst_r      <= dst_nxt;
    wen_r      <= wen_nxt;
    fault_r    <= fault_nxt;
    neg_r      <= neg_nxt;
    opa_r      <= opa_nxt;
    opb_r      <= opb_nxt;
    res_r      <= res_nxt;
    cnt_r      <= cnt_nxt;
    npc_r      <= npc_nxt;
    out_data_r <= out_data_nxt;
  end

  // A new result is loaded only when the sequencer commits an instruction
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_DONE)
    else $error("result appeared without a committed instruction");

  // An accepted instruction keeps the input busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready && (state_r == S_EXEC))
    else $error("input ready right after an accepted instruction");

  // A fault comes only from a suppressed divide that writes nothing
  a_fault_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && fault_r |-> (act_r == trie_pkg::ACT_DIV) && !wen_r)
    else $error("fault raised outside a suppressed divide");

endmodule

// ----- tb/tb_three_register_instruction_executor.sv -----
// Self-checking testbench for the three-register instruction executor.
`timescale 1ns / 1ps

module tb_three_register_instruction_executor;

  // Codes with no name in the package.
  localparam logic [3:0]                  ACT_OTHER = 4'd10;
  localparam logic [3:0]                  ACT_LAST  = 4'd15;
  localparam logic [trie_pkg::DATA_W-1:0] INT_MAX   = ~trie_pkg::INT_MIN;

  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 470;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [trie_pkg::IN_W-1:0]   in_tdata = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [trie_pkg::OUT_W-1:0]  out_tdata;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [trie_pkg::DATA_W-1:0] cfg_data = '0;

  // Machine state as the checker expects it to be.
  logic [trie_pkg::DATA_W-1:0] m_reg [3];
  logic [trie_pkg::DATA_W-1:0] m_loop;
  logic [15:0]                 m_pc;

  trie_pkg::out_item_t state_q[$];
  int                  n_mismatch = 0;
  int                  idle_cycles = 0;
  logic                no_idle = 1'b0;

  three_register_instruction_executor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Executes one instruction on the expected state and returns the machine state after it.
  function automatic trie_pkg::out_item_t exec_instr(input trie_pkg::in_item_t it);
    trie_pkg::out_item_t r;
    logic [15:0]         nxt;
    logic [31:0]         s;
    logic [31:0]         d;
    logic                have;
    logic                flt;
    nxt  = m_pc + 16'(it.instr_length);
    flt  = 1'b0;
    have = 1'b0;
    s    = '0;
    d    = '0;
    if (it.src_is_reg) begin
      if (it.src_reg != trie_pkg::REG_NONE) begin
        have = 1'b1;
        s    = m_reg[it.src_reg];
      end
    end else if (it.immediate != '0) begin
      have = 1'b1;
      s    = it.immediate;
    end
    case (it.action)
      trie_pkg::ACT_ADD, trie_pkg::ACT_SUB, trie_pkg::ACT_MUL, trie_pkg::ACT_DIV,
      trie_pkg::ACT_MOVE: begin
        if (it.dest_reg != trie_pkg::REG_NONE && have) begin
          d = m_reg[it.dest_reg];
          case (it.action)
            trie_pkg::ACT_ADD: m_reg[it.dest_reg] = d + s;
            trie_pkg::ACT_SUB: m_reg[it.dest_reg] = d - s;
            trie_pkg::ACT_MUL: m_reg[it.dest_reg] = d * s;
            trie_pkg::ACT_DIV: begin
              // Zero divisor and the one overflowing quotient are suppressed.
              if (s == '0 || (d == trie_pkg::INT_MIN && s == trie_pkg::MINUS_ONE)) flt = 1'b1;
              else m_reg[it.dest_reg] = $signed(d) / $signed(s);
            end
            default: m_reg[it.dest_reg] = s;
          endcase
        end
      end
      trie_pkg::ACT_INC: begin
        if (it.dest_reg != trie_pkg::REG_NONE)
          m_reg[it.dest_reg] = m_reg[it.dest_reg] + trie_pkg::ONE;
      end
      trie_pkg::ACT_DEC: begin
        if (it.dest_reg != trie_pkg::REG_NONE)
          m_reg[it.dest_reg] = m_reg[it.dest_reg] - trie_pkg::ONE;
      end
      trie_pkg::ACT_LOAD: begin
        if (it.dest_reg != trie_pkg::REG_NONE) m_reg[it.dest_reg] = it.mem_value;
      end
      trie_pkg::ACT_JUMP: nxt = it.jump_target;
      trie_pkg::ACT_CJMP: begin
        // Branch test uses the loop value before its decrement.
        if ($signed(m_loop) > 0) nxt = it.jump_target;
        m_loop = m_loop - trie_pkg::ONE;
      end
      default: ;
    endcase
    m_pc       = nxt;
    r          = '0;
    r.out_a    = m_reg[trie_pkg::REG_A];
    r.out_b    = m_reg[trie_pkg::REG_B];
    r.out_c    = m_reg[trie_pkg::REG_C];
    r.out_loop = m_loop;
    r.next_pc  = m_pc;
    r.fault    = flt;
    return r;
  endfunction

  function automatic trie_pkg::in_item_t mk(input logic [3:0] act, input logic [1:0] dst,
                                            input logic sir, input logic [1:0] src,
                                            input logic [31:0] imm, input logic [31:0] mem,
                                            input logic [15:0] tgt, input logic [7:0] len);
    trie_pkg::in_item_t it;
    it              = '0;
    it.action       = act;
    it.dest_reg     = dst;
    it.src_is_reg   = sir;
    it.src_reg      = src;
    it.immediate    = imm;
    it.mem_value    = mem;
    it.jump_target  = tgt;
    it.instr_length = len;
    return it;
  endfunction

  // Data words biased toward the corner values.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return trie_pkg::INT_MIN;
      2:       return trie_pkg::MINUS_ONE;
      3:       return INT_MAX;
      4:       return trie_pkg::ONE;
      5, 6:    return 32'($urandom_range(16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Mostly valid operations and registers, with unused codes mixed in.
  function automatic trie_pkg::in_item_t rand_instr();
    trie_pkg::in_item_t it;
    it              = '0;
    it.action       = ($urandom_range(99) < 92) ? 4'($urandom_range(9))
                                                : 4'($urandom_range(10, 15));
    it.dest_reg     = ($urandom_range(99) < 90) ? 2'($urandom_range(2)) : trie_pkg::REG_NONE;
    it.src_is_reg   = 1'($urandom_range(1));
    it.src_reg      = ($urandom_range(99) < 90) ? 2'($urandom_range(2)) : trie_pkg::REG_NONE;
    it.immediate    = rand_word();
    it.mem_value    = rand_word();
    it.jump_target  = 16'($urandom);
    it.instr_length = ($urandom_range(49) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    return it;
  endfunction

  // Sends one instruction and records the state it must produce.
  task automatic send_instr(input trie_pkg::in_item_t it);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= it;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    state_q.push_back(exec_instr(it));
  endtask

  // Holds the sender off until every outstanding result has been seen.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (state_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_loop_start(input logic [31:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_loop = v;
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
    end
  endtask

  // Arithmetic corners, suppressed writes, wrap of the pc and unused codes.
  task automatic test_directed_ops();
    send_instr(mk(trie_pkg::ACT_LOAD, trie_pkg::REG_A, 1'b0, trie_pkg::REG_A,
                  '0, INT_MAX, '0, 8'd1));
    send_instr(mk(trie_pkg::ACT_LOAD, trie_pkg::REG_B, 1'b0, trie_pkg::REG_A,
                  '0, trie_pkg::INT_MIN, '0, 8'd255));
    send_instr(mk(trie_pkg::ACT_ADD, trie_pkg::REG_A, 1'b0, trie_pkg::REG_A,
                  trie_pkg::ONE, '0, '0, 8'd1));
    send_instr(mk(trie_pkg::ACT_SUB, trie_pkg::REG_C, 1'b0, trie_pkg::REG_A,
                  '0, '0, '0, 8'd1));
    send_instr(mk(trie_pkg::ACT_LOAD, trie_pkg::REG_C, 1'b0, trie_pkg::REG_A,
                  '0, trie_pkg::MINUS_ONE, '0, 8'd2));
    send_instr(mk(trie_pkg::ACT_DIV, trie_pkg::REG_B, 1'b1, trie_pkg::REG_C,
                  '0, '0, '0, 8'd3));
    send_instr(mk(trie_pkg::ACT_DIV, trie_pkg::REG_A, 1'b0, trie_pkg::REG_A,
                  trie_pkg::MINUS_ONE, '0, '0, 8'd3));
    send_instr(mk(trie_pkg::ACT_LOAD, trie_pkg::REG_C, 1'b0, trie_pkg::REG_A,
                  '0, '0, '0, 8'd2));
    send_instr(mk(trie_pkg::ACT_DIV, trie_pkg::REG_A, 1'b1, trie_pkg::REG_C,
                  '0, '0, '0, 8'd3));
    send_instr(mk(trie_pkg::ACT_DIV, trie_pkg::REG_B, 1'b0, trie_pkg::REG_A,
                  32'd3, '0, '0, 8'd3));
    send_instr(mk(trie_pkg::ACT_LOAD, trie_pkg::REG_C, 1'b0, trie_pkg::REG_A,
                  '0, -32'sd7, '0, 8'd2));
    send_instr(mk(trie_pkg::ACT_MUL, trie_pkg::REG_B, 1'b1, trie_pkg::REG_C,
                  '0, '0, '0, 8'd4));
    send_instr(mk(trie_pkg::ACT_MOVE, trie_pkg::REG_A, 1'b1, trie_pkg::REG_A,
                  '0, '0, '0, 8'd1));
    send_instr(mk(trie_pkg::ACT_MOVE, trie_pkg::REG_B, 1'b0, trie_pkg::REG_A,
                  32'h5A5A_A5A5, '0, '0, 8'd6));
    send_instr(mk(trie_pkg::ACT_MOVE, trie_pkg::REG_C, 1'b1, trie_pkg::REG_B,
                  '0, '0, '0, 8'd1));
    send_instr(mk(trie_pkg::ACT_INC, trie_pkg::REG_A, 1'b0, trie_pkg::REG_A,
                  '0, '0, '0, 8'd1));
    send_instr(mk(trie_pkg::ACT_INC, trie_pkg::REG_NONE, 1'b0, trie_pkg::REG_A,
                  '0, trie_pkg::MINUS_ONE, '0, 8'd1));
    send_instr(mk(trie_pkg::ACT_ADD, trie_pkg::REG_A, 1'b1, trie_pkg::REG_NONE,
                  trie_pkg::MINUS_ONE, '0, '0, 8'd1));
    send_instr(mk(trie_pkg::ACT_JUMP, trie_pkg::REG_A, 1'b0, trie_pkg::REG_A,
                  '0, '0, 16'hFFFF, 8'd3));
    send_instr(mk(ACT_OTHER, trie_pkg::REG_A, 1'b0, trie_pkg::REG_A,
                  '0, '0, '0, 8'd255));
    send_instr(mk(ACT_LAST, trie_pkg::REG_B, 1'b1, trie_pkg::REG_B,
                  trie_pkg::MINUS_ONE, trie_pkg::MINUS_ONE, 16'hFFFF, 8'd1));
    wait_results();
  endtask

  // Loop register counting down across zero and from the negative extreme.
  task automatic test_counted_jump();
    write_loop_start(32'd2);
    repeat (3) send_instr(mk(trie_pkg::ACT_CJMP, trie_pkg::REG_A, 1'b0, trie_pkg::REG_A,
                             '0, '0, 16'h1234, 8'd2));
    wait_results();
    write_loop_start(trie_pkg::INT_MIN);
    send_instr(mk(trie_pkg::ACT_CJMP, trie_pkg::REG_A, 1'b0, trie_pkg::REG_A,
                  '0, '0, 16'hABCD, 8'd2));
    send_instr(mk(trie_pkg::ACT_CJMP, trie_pkg::REG_A, 1'b0, trie_pkg::REG_A,
                  '0, '0, 16'h0042, 8'd2));
    wait_results();
  endtask

  // Random programs in phases, each starting from a new loop value.
  task automatic test_random_programs();
    logic [31:0] starts [4];
    starts = '{INT_MAX, 32'd5, trie_pkg::INT_MIN, $urandom};
    for (int p = 0; p < 4; p++) begin
      write_loop_start(starts[p]);
      // The second phase runs with both sides always ready.
      no_idle = (p == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_instr(rand_instr());
        if ($urandom_range(199) == 0) wait_results();
      end
      wait_results();
      no_idle = 1'b0;
    end
  endtask

  // Result checking and receiver back-pressure.
  always @(posedge clk) begin
    trie_pkg::out_item_t got;
    trie_pkg::out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (state_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("%0t: unexpected result %h", $time, out_tdata);
      end else begin
        want = state_q.pop_front();
        check_field("out_a", want.out_a, got.out_a);
        check_field("out_b", want.out_b, got.out_b);
        check_field("out_c", want.out_c, got.out_c);
        check_field("out_loop", want.out_loop, got.out_loop);
        check_field("next_pc", 32'(want.next_pc), 32'(got.next_pc));
        check_field("fault", 32'(want.fault), 32'(got.fault));
      end
    end
    out_tready <= no_idle || ($urandom_range(99) >= 33);
  end

  // Watchdog on cycles with no transfer on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    m_reg  = '{default: '0};
    m_loop = '0;
    m_pc   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_counted_jump();
    test_random_programs();
    wait_results();
    repeat (50) @(posedge clk);
    if (n_mismatch == 0 && state_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/trie_pkg.sv
src/three_register_instruction_executor.sv
tb/tb_three_register_instruction_executor.sv
